/* hdl/dee_pkg.sv */
// ----------------------------------------------------------------------------
// dee_pkg
// Shared types and constants of the dictionary escape expander.
// ----------------------------------------------------------------------------
`default_nettype none

package dee_pkg;

    // Word store layout: word n, byte p sits at {n, p}
    localparam int WORD_W  = 7;
    localparam int POS_W   = 6;
    localparam int STORE_AW = WORD_W + POS_W;
    localparam int LEN_W   = 7;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    typedef enum logic [1:0] {
        PH_OPEN,
        PH_HEAD,
        PH_BODY,
        PH_ESC
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_LEN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       message_done;
        logic       run_last;
    } t_result;

endpackage

`default_nettype wire

/* hdl/dee_ram.sv */
// ----------------------------------------------------------------------------
// dee_ram
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/dee_out_buf.sv */
// ----------------------------------------------------------------------------
// dee_out_buf
// One-entry output register; refills in the cycle it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module dee_out_buf
    import dee_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    output logic         o_can_push,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_push = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_push) begin
            r_valid <= i_push;
        end
    end

    // hold payload until taken
    always_ff @(posedge i_clk) begin
        if (o_can_push && i_push) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

/* hdl/dictionary_escape_expander.sv */
// ----------------------------------------------------------------------------
// dictionary_escape_expander
// Dictionary substitution decompressor: header words stored in memory,
// '@' escapes in the body expanded from it.
// ----------------------------------------------------------------------------
// The first byte of a message opens a header of comma-separated words that
// ends at '>'; words are numbered from 1 and kept in a byte memory (64 slots
// per word) plus a length memory. Body bytes pass through, except that '@'
// makes the next byte a word number whose bytes are then emitted. A
// word-number byte for a word that does not exist emits nothing; otherwise
// the length memory is read first, then the word's bytes follow at one byte
// per cycle from the single read port of the byte memory while the output
// register can take them. Input items are taken only while no expansion is
// under way and the output register can take a result. The memories need no
// clearing after reset: only words written in the current message are read.
// ----------------------------------------------------------------------------
`default_nettype none

module dictionary_escape_expander
    import dee_pkg::*;
#(
    parameter int MAX_WORDS    = 127,
    parameter int MAX_WORD_LEN = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // end_of_message
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [8] run_last, rest 0
    output logic             m_axis_tuser,   // byte_valid
    output logic             m_axis_tlast    // message_done
);

    // ---------------- state registers ----------------
    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [7:0]         r_total, n_total;   // words stored
    logic [LEN_W-1:0]   r_wp,    n_wp;      // length of open header word
    logic               r_eom,   n_eom;     // expansion ends the message
    logic [WORD_W-1:0]  r_word,  n_word;    // word being expanded
    logic [LEN_W-1:0]   r_len,   n_len;
    logic [LEN_W-1:0]   r_cnt,   n_cnt;     // bytes of the word emitted

    // ---------------- memory ports ----------------
    logic                byte_we;
    logic [STORE_AW-1:0] byte_waddr;
    logic [7:0]          byte_wdata;
    logic [STORE_AW-1:0] byte_raddr;
    logic [7:0]          byte_rdata;

    logic                len_we;
    logic [WORD_W-1:0]   len_waddr;
    logic [LEN_W-1:0]    len_wdata;
    logic [WORD_W-1:0]   len_raddr;
    logic [LEN_W-1:0]    len_rdata;

    // ---------------- output register ----------------
    logic    push;
    t_result result;
    logic    can_push;
    t_result out_result;

    logic accept;

    dee_ram #(
        .WIDTH (8),
        .DEPTH (1 << STORE_AW)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (byte_wdata),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rdata)
    );

    dee_ram #(
        .WIDTH (LEN_W),
        .DEPTH (1 << WORD_W)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    dee_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_result   (result),
        .o_can_push (can_push),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (out_result)
    );

    assign m_axis_tdata  = {7'd0, out_result.run_last, out_result.out_byte};
    assign m_axis_tuser  = out_result.byte_valid;
    assign m_axis_tlast  = out_result.message_done;

    assign s_axis_tready = (r_state == ST_RUN) && can_push;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ---------------- state register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_phase <= PH_OPEN;
            r_total <= 8'd0;
            r_wp    <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_total <= n_total;
            r_wp    <= n_wp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eom  <= n_eom;
        r_word <= n_word;
        r_len  <= n_len;
        r_cnt  <= n_cnt;
    end

    // ---------------- next state and datapath ----------------
    always_comb begin
        logic [7:0]       v_total;
        logic             v_go_len;
        logic [LEN_W-1:0] v_cnt_inc;
        logic             v_last;

        n_state = r_state;
        n_phase = r_phase;
        n_total = r_total;
        n_wp    = r_wp;
        n_eom   = r_eom;
        n_word  = r_word;
        n_len   = r_len;
        n_cnt   = r_cnt;

        byte_we    = 1'b0;
        byte_waddr = {r_total[WORD_W-1:0], r_wp[POS_W-1:0]};
        byte_wdata = s_axis_tdata;
        byte_raddr = {r_word, r_cnt[POS_W-1:0]};
        len_we     = 1'b0;
        len_waddr  = r_total[WORD_W-1:0];
        len_wdata  = '0;
        len_raddr  = s_axis_tdata[WORD_W-1:0];

        push                = 1'b0;
        result.out_byte     = s_axis_tdata;
        result.byte_valid   = 1'b1;
        result.message_done = 1'b0;
        result.run_last     = 1'b1;

        v_total   = r_total;
        v_go_len  = 1'b0;
        v_cnt_inc = r_cnt + LEN_W'(1);
        v_last    = (v_cnt_inc == r_len);

        case (r_state)
            ST_RUN: begin
                if (accept) begin
                    n_eom = s_axis_tlast;
                    case (r_phase)
                        PH_OPEN: begin
                            n_phase = PH_HEAD;
                            n_wp    = '0;
                        end
                        PH_HEAD: begin
                            if (s_axis_tdata == CH_GT) begin
                                n_phase = PH_BODY;
                                n_wp    = '0;
                            end else if (s_axis_tdata == CH_COMMA) begin
                                // comma with no word open stores an empty word
                                if (r_wp == '0 && r_total < 8'(MAX_WORDS)) begin
                                    v_total   = r_total + 8'd1;
                                    n_total   = v_total;
                                    len_we    = 1'b1;
                                    len_waddr = v_total[WORD_W-1:0];
                                    len_wdata = '0;
                                end
                                n_wp = '0;
                            end else if (!(r_wp == '0 && r_total >= 8'(MAX_WORDS))) begin
                                v_total = (r_wp == '0) ? r_total + 8'd1 : r_total;
                                n_total = v_total;
                                // drop bytes past the length limit
                                if (r_wp < LEN_W'(MAX_WORD_LEN)) begin
                                    byte_we    = 1'b1;
                                    byte_waddr = {v_total[WORD_W-1:0], r_wp[POS_W-1:0]};
                                    n_wp       = r_wp + LEN_W'(1);
                                    len_we     = 1'b1;
                                    len_waddr  = v_total[WORD_W-1:0];
                                    len_wdata  = r_wp + LEN_W'(1);
                                end
                            end
                        end
                        PH_BODY: begin
                            if (s_axis_tdata == CH_AT) begin
                                n_phase = PH_ESC;
                            end else begin
                                push = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = PH_BODY;
                            if (s_axis_tdata[7] == 1'b0 && s_axis_tdata != 8'd0 &&
                                s_axis_tdata <= r_total) begin
                                v_go_len = 1'b1;
                                n_word   = s_axis_tdata[WORD_W-1:0];
                                n_state  = ST_LEN;
                            end
                        end
                    endcase

                    if (s_axis_tlast) begin
                        // end marker when this item gives no byte
                        if (!push && !v_go_len) begin
                            push              = 1'b1;
                            result.out_byte   = 8'd0;
                            result.byte_valid = 1'b0;
                        end
                        result.message_done = push;
                        n_phase = PH_OPEN;
                        n_total = 8'd0;
                        n_wp    = '0;
                    end
                end
            end
            ST_LEN: begin
                // hold the length read on the word while an end marker waits
                len_raddr  = r_word;
                n_len      = len_rdata;
                n_cnt      = '0;
                byte_raddr = {r_word, {POS_W{1'b0}}};
                if (len_rdata != '0) begin
                    n_state = ST_EMIT;
                end else if (!r_eom) begin
                    n_state = ST_RUN;
                end else if (can_push) begin
                    push                = 1'b1;
                    result.out_byte     = 8'd0;
                    result.byte_valid   = 1'b0;
                    result.message_done = 1'b1;
                    n_state             = ST_RUN;
                end
            end
            ST_EMIT: begin
                result.out_byte     = byte_rdata;
                result.run_last     = v_last;
                result.message_done = v_last && r_eom;
                if (can_push) begin
                    push       = 1'b1;
                    n_cnt      = v_cnt_inc;
                    byte_raddr = {r_word, v_cnt_inc[POS_W-1:0]};
                    if (v_last) begin
                        n_state = ST_RUN;
                    end
                end else begin
                    // re-read the same byte while the output stalls
                    byte_raddr = {r_word, r_cnt[POS_W-1:0]};
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> r_cnt < r_len && r_len <= LEN_W'(MAX_WORD_LEN))
        else $error("expansion count out of range");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && push && result.run_last) |=> r_state == ST_RUN)
        else $error("expansion did not stop after its last byte");

    a_word_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= 8'(MAX_WORDS) && r_wp <= LEN_W'(MAX_WORD_LEN))
        else $error("header word count or length past limit");

    a_no_take_in_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_ESC && n_state == ST_LEN) |=>
            (r_state == ST_LEN && !s_axis_tready))
        else $error("input taken during word expansion");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dictionary_escape_expander: messages with headers
// of comma-separated words and bodies of literals and '@' escapes are streamed
// in; every result item is checked against a cycle-free expansion predictor.
// ----------------------------------------------------------------------------

module testbench;

    import dee_pkg::*;

    localparam int MAX_WORDS    = 127;
    localparam int MAX_WORD_LEN = 64;

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0; // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [7:0] out_byte, [8] run_last, rest 0
    logic        m_axis_tuser;        // byte_valid
    logic        m_axis_tlast;        // message_done

    always #4 i_clk = ~i_clk;

    dictionary_escape_expander dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------------
    // Run bookkeeping
    // ------------------------------------------------------------------------
    bit          idling_on = 1'b1;    // random gaps and stalls allowed
    int          items_sent;
    int          messages_sent;
    int          results_seen;
    int          word_expansions;
    int          mismatch_count;
    logic [7:0]  msg_buf[$];          // message being assembled for sending

    // ------------------------------------------------------------------------
    // Expansion predictor: its own copy of the dictionary and parse phase
    // ------------------------------------------------------------------------
    t_phase      parse_phase;
    logic [7:0]  word_count;
    logic [6:0]  open_len;            // length of the open header word, 0 = none
    logic [7:0]  word_mem [0:127][0:MAX_WORD_LEN-1];
    logic [6:0]  word_len [0:127];
    t_result     pending_out[$];      // expected result items, oldest first

    function automatic t_result make_result(input logic [7:0] data, input logic valid);
        t_result r;
        r.out_byte     = data;
        r.byte_valid   = valid;
        r.message_done = 1'b0;
        r.run_last     = 1'b0;
        return r;
    endfunction

    function automatic void clear_dictionary();
        parse_phase = PH_OPEN;
        word_count  = '0;
        open_len    = '0;
    endfunction

    // Work out the result items that one accepted input item causes.
    function automatic void expand_byte(input logic [7:0] b, input logic last);
        t_result run_q[$];
        t_result r;
        bit      take;
        logic [6:0] slot;
        case (parse_phase)
            PH_OPEN: begin
                // the opening byte only starts the header
                parse_phase = PH_HEAD;
                open_len    = '0;
            end
            PH_HEAD: begin
                if (b == CH_GT) begin
                    parse_phase = PH_BODY;
                    open_len    = '0;
                end else if (b == CH_COMMA) begin
                    // a comma with no word open stores an empty word
                    if (open_len == 0 && word_count < MAX_WORDS) begin
                        word_count = word_count + 8'd1;
                        word_len[word_count[6:0]] = '0;
                    end
                    open_len = '0;
                end else begin
                    take = 1'b1;
                    if (open_len == 0) begin
                        if (word_count >= MAX_WORDS) begin
                            take = 1'b0;   // dictionary full: ignore
                        end else begin
                            word_count = word_count + 8'd1;
                            word_len[word_count[6:0]] = '0;
                        end
                    end
                    // bytes past the length limit are dropped
                    if (take && open_len < MAX_WORD_LEN) begin
                        word_mem[word_count[6:0]][open_len[5:0]] = b;
                        open_len = open_len + 7'd1;
                        word_len[word_count[6:0]] = open_len;
                    end
                end
            end
            PH_BODY: begin
                if (b == CH_AT) parse_phase = PH_ESC;
                else run_q.push_back(make_result(b, 1'b1));
            end
            default: begin
                parse_phase = PH_BODY;
                slot = b[6:0];
                if (b >= 1 && b <= 127 && b <= word_count) begin
                    word_expansions++;
                    for (int p = 0; p < word_len[slot]; p++)
                        run_q.push_back(make_result(word_mem[slot][p[5:0]], 1'b1));
                end
            end
        endcase

        if (last) begin
            // nothing emitted on the final item: a bare end marker
            if (run_q.size() == 0) run_q.push_back(make_result(8'h00, 1'b0));
            r = run_q.pop_back();
            r.message_done = 1'b1;
            run_q.push_back(r);
            clear_dictionary();
            messages_sent++;
        end
        if (run_q.size() > 0) begin
            r = run_q.pop_back();
            r.run_last = 1'b1;
            run_q.push_back(r);
        end
        foreach (run_q[i]) pending_out.push_back(run_q[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, and a check of every accepted item
    // ------------------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (i_rst_n && idling_on && $urandom_range(0, 7) == 0) begin
            // start a stall burst, counting this one; stall_left holds the rest of it
            stall_left    <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic note_mismatch(input string what, input t_result want,
                                 input t_result seen);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t ns: %s: expected byte %02h valid %0b done %0b last %0b, ",
                      "got byte %02h valid %0b done %0b last %0b tdata %04h"},
                     $realtime, what, want.out_byte, want.byte_valid, want.message_done,
                     want.run_last, seen.out_byte, seen.byte_valid, seen.message_done,
                     seen.run_last, m_axis_tdata);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result seen;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.out_byte     = m_axis_tdata[7:0];
            seen.byte_valid   = m_axis_tuser;
            seen.message_done = m_axis_tlast;
            seen.run_last     = m_axis_tdata[8];
            results_seen++;
            if (pending_out.size() == 0) begin
                note_mismatch("result with nothing expected", '0, seen);
            end else begin
                want = pending_out.pop_front();
                if (seen.out_byte !== want.out_byte || seen.byte_valid !== want.byte_valid
                    || seen.message_done !== want.message_done
                    || seen.run_last !== want.run_last || m_axis_tdata[15:9] !== '0)
                    note_mismatch("result mismatch", want, seen);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Present one item, sometimes after a random gap, and hold it until taken.
    task automatic send_item(input logic [7:0] data, input logic last);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        expand_byte(data, last);
    endtask

    // Send the assembled message, marking its final item.
    task automatic send_message();
        foreach (msg_buf[i]) send_item(msg_buf[i], i == msg_buf.size() - 1);
        msg_buf.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
    endtask

    task automatic add_escape(input logic [7:0] number);
        msg_buf.push_back(CH_AT);
        msg_buf.push_back(number);
    endtask

    // Hold the input idle until every expected result has come.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
    endtask

    // Any byte that neither separates nor closes a header word.
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_COMMA || c == CH_GT);
        return c;
    endfunction

    function automatic logic [7:0] literal_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_AT);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Header words: zero byte, empty word, close-only comma; body extremes,
    // bad word numbers and a trailing escape on the final item.
    task automatic test_header_and_escapes();
        msg_buf.push_back(8'hFF);           // opener, otherwise ignored
        add_text("a");
        msg_buf.push_back(8'h00);           // zero byte inside a word
        add_text(",,c,>");                  // word 1 "a\0", word 2 empty, word 3 "c"
        msg_buf.push_back(8'h00);
        msg_buf.push_back(8'hFF);
        add_escape(8'd1);
        add_escape(8'd2);                   // empty word emits nothing
        add_escape(8'd3);
        add_escape(8'd0);                   // bad numbers
        add_escape(8'd128);
        add_escape(8'd4);                   // above the word count
        add_text("z@");                     // trailing escape dropped
        send_message();
    endtask

    // Header that never closes, and a message whose last item emits nothing.
    task automatic test_short_messages();
        add_text("Xpq");
        send_message();
        add_text("O,>");                    // one empty word
        add_escape(8'd1);
        send_message();
        msg_buf.push_back(8'h00);           // single-item message
        send_message();
    endtask

    // Word longer than the length limit is cut to its first 64 bytes.
    task automatic test_long_word();
        add_text("L");
        for (int i = 0; i < 70; i++) msg_buf.push_back(8'(8'h41 + (i % 26)));
        add_text(",bc>");
        add_escape(8'd1);
        add_escape(8'd2);
        add_escape(8'd1);                   // maximum results on the final item
        send_message();
    endtask

    // Fill the dictionary to its word limit, then try to add more.
    task automatic test_word_limit();
        add_text("Wxy");
        repeat (126) add_text(",");         // close word 1, then 125 empty words
        add_text("z,qr,>");                 // word 127 "z"; the rest is ignored
        add_escape(8'd127);
        add_escape(8'd1);
        add_escape(8'd64);
        add_escape(8'd255);
        add_text("k");
        send_message();
    endtask

    // Mostly well-formed messages with random content; some cut short, some
    // pure noise.
    task automatic test_random_traffic(input int item_goal);
        int goal;
        int kind;
        int n_words;
        int body_len;
        goal = items_sent + item_goal;
        while (items_sent < goal) begin
            kind = $urandom_range(0, 19);
            if (kind < 2) begin
                // noise: any bytes at all
                repeat ($urandom_range(1, 8))
                    msg_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                msg_buf.push_back(8'($urandom_range(0, 255)));
                n_words = $urandom_range(0, 6);
                for (int w = 0; w < n_words; w++) begin
                    repeat ($urandom_range(0, 5)) msg_buf.push_back(word_char());
                    if (w < n_words - 1 || $urandom_range(0, 1)) msg_buf.push_back(CH_COMMA);
                end
                msg_buf.push_back(CH_GT);
                body_len = $urandom_range(1, 12);
                for (int k = 0; k < body_len; k++) begin
                    if ($urandom_range(0, 99) < 40) begin
                        if ($urandom_range(0, 9) < 7)
                            add_escape(8'($urandom_range(1, n_words + 1)));
                        else
                            add_escape(8'($urandom_range(0, 255)));
                    end else begin
                        msg_buf.push_back(literal_char());
                    end
                end
                // broken message: cut at a random point
                if (kind < 5)
                    while (msg_buf.size() > 1 && $urandom_range(0, 2) != 0)
                        void'(msg_buf.pop_back());
            end
            send_message();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_dictionary();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_and_escapes();
        drain_results();
        test_short_messages();
        test_long_word();
        drain_results();
        test_word_limit();
        test_random_traffic(70);

        // last stretch at full rate on both sides
        drain_results();
        idling_on = 1'b0;
        test_random_traffic(40);

        drain_results();
        repeat (16) @(posedge i_clk);
        if (pending_out.size() != 0) mismatch_count++;

        $display("Covered %0d messages in %0d input items, %0d results checked.",
                 messages_sent, items_sent, results_seen);
        $display("Words expanded: %0d; mismatches: %0d.", word_expansions, mismatch_count);
        if (mismatch_count == 0) begin
            $display("dictionary_escape_expander regression: pass");
        end else begin
            $display("dictionary_escape_expander regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("Timeout with %0d results still expected.", pending_out.size());
        $display("dictionary_escape_expander regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
hdl/dee_pkg.sv
hdl/dee_ram.sv
hdl/dee_out_buf.sv
hdl/dictionary_escape_expander.sv
tb/testbench.sv
